>>> hdl/htfd_pkg.sv
// ----------------------------------------------------------------------------
// Humidity and temperature frame decoder package
// Shared types, constants and the CRC-8 step used by the decoder modules.
// ----------------------------------------------------------------------------
package htfd_pkg;

   // Frame layout: six data bytes, then the received CRC byte.
   localparam int unsigned DATA_BYTES = 6;
   localparam int unsigned INDEX_W    = 3;

   // CRC-8 with polynomial x^8 + x^5 + x^4 + 1, MSB first.
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   // Field widths of a result item.
   localparam int unsigned RAW_W   = 20;
   localparam int unsigned HUM_W   = 14;
   localparam int unsigned TEMP_W  = 15;

   // Fixed-point scale factors: hundredths per full-scale 2^20.
   localparam logic [13:0] HUM_SCALE   = 14'd10000;
   localparam logic [14:0] TEMP_SCALE  = 15'd20000;
   localparam logic [14:0] TEMP_OFFSET = 15'd5000;
   localparam int unsigned HUM_PROD_W  = RAW_W + 14;
   localparam int unsigned TEMP_PROD_W = RAW_W + 15;

   // Queue between the byte front end and the scaling back end.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BUSY    = 2'd1,
      STATUS_CRC_ERR = 2'd2
   } status_type;

   // One classified frame as handed from front end to back end.
   typedef struct packed {
      status_type         status;
      logic [RAW_W-1:0]   humidity_raw;
      logic [RAW_W-1:0]   temperature_raw;
   } frame_type;

   // One CRC-8 update over a full byte, eight shift steps.
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> hdl/htfd_front.sv
// ----------------------------------------------------------------------------
// Frame decoder front end
// Takes response bytes, keeps the byte index, the running CRC and the data
// bytes, and on the seventh byte pushes a classified frame into the queue.
// ----------------------------------------------------------------------------
module htfd_front
   import htfd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_rx_byte,
   input  logic             req_frame_start,
   output logic             push_valid,
   input  logic             push_ready,
   output frame_type        push_data
);

   logic [INDEX_W-1:0] byte_index_ff;
   logic [INDEX_W-1:0] byte_index_in;
   logic [7:0]         crc_ff;
   logic [7:0]         crc_in;
   logic [7:0]         frame_bytes_ff [DATA_BYTES];

   logic [INDEX_W-1:0] index_now;
   logic [7:0]         crc_now;
   logic               last_byte;
   logic               accept;

   // A start marker restarts the frame before this byte is taken.
   assign index_now = req_frame_start ? '0 : byte_index_ff;
   assign crc_now   = req_frame_start ? CRC_INIT : crc_ff;
   assign last_byte = (index_now >= INDEX_W'(DATA_BYTES));

   // Items are taken only while the queue has room for a possible result.
   assign req_ready  = push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = req_valid && last_byte;

   // Classify the completed frame and assemble the raw values.
   always_comb begin
      push_data = '0;
      if (frame_bytes_ff[0][7]) begin
         push_data.status = STATUS_BUSY;
      end else if (crc_now != req_rx_byte) begin
         push_data.status = STATUS_CRC_ERR;
      end else begin
         push_data.status          = STATUS_OK;
         push_data.humidity_raw    = {frame_bytes_ff[1], frame_bytes_ff[2],
                                      frame_bytes_ff[3][7:4]};
         push_data.temperature_raw = {frame_bytes_ff[3][3:0], frame_bytes_ff[4],
                                      frame_bytes_ff[5]};
      end
   end

   // Next index and CRC.
   always_comb begin
      byte_index_in = byte_index_ff;
      crc_in        = crc_ff;
      if (accept) begin
         if (last_byte) begin
            byte_index_in = '0;
            crc_in        = CRC_INIT;
         end else begin
            byte_index_in = index_now + INDEX_W'(1);
            crc_in        = crc8_step(crc_now, req_rx_byte);
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         crc_ff        <= CRC_INIT;
      end else begin
         byte_index_ff <= byte_index_in;
         crc_ff        <= crc_in;
      end
   end

   // Data byte capture.
   always_ff @(posedge clock) begin
      if (accept && !last_byte) begin
         frame_bytes_ff[index_now] <= req_rx_byte;
      end
   end

endmodule

>>> hdl/htfd_queue.sv
// ----------------------------------------------------------------------------
// Frame decoder queue
// Short first-in first-out buffer of classified frames between the front end
// and the back end.
// ----------------------------------------------------------------------------
module htfd_queue
   import htfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   output logic       push_ready,
   input  frame_type  push_data,
   output logic       pop_valid,
   input  logic       pop_ready,
   output frame_type  pop_data
);

   frame_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff;
   logic [QUEUE_CNT_W-1:0]   count_in;
   logic                     do_push;
   logic                     do_pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/htfd_back.sv
// ----------------------------------------------------------------------------
// Frame decoder back end
// Two-stage pipeline: the first stage multiplies the raw values by their
// scale factors, the second shifts, offsets and holds the result item.
// ----------------------------------------------------------------------------
module htfd_back
   import htfd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   output logic                      pop_ready,
   input  frame_type                 pop_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output logic [RAW_W-1:0]          rsp_humidity_raw,
   output logic [RAW_W-1:0]          rsp_temperature_raw,
   output logic [HUM_W-1:0]          rsp_humidity_centi,
   output logic signed [TEMP_W-1:0]  rsp_temperature_centi
);

   // Stage one registers.
   logic                    s1_valid_ff;
   logic                    s1_valid_in;
   frame_type               s1_frame_ff;
   logic [HUM_PROD_W-1:0]   s1_hum_prod_ff;
   logic [TEMP_PROD_W-1:0]  s1_temp_prod_ff;

   // Stage two (output) registers.
   logic                    s2_valid_ff;
   logic                    s2_valid_in;
   status_type              s2_status_ff;
   logic [RAW_W-1:0]        s2_hum_raw_ff;
   logic [RAW_W-1:0]        s2_temp_raw_ff;
   logic [HUM_W-1:0]        s2_hum_centi_ff;
   logic [TEMP_W-1:0]       s2_temp_centi_ff;
   logic [HUM_W-1:0]        s2_hum_centi_in;
   logic [TEMP_W-1:0]       s2_temp_centi_in;

   logic                    s1_ready;
   logic                    s2_ready;
   logic                    s1_load;
   logic                    s2_load;

   // Each stage moves when the one after it has room.
   assign s2_ready  = !s2_valid_ff || rsp_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign pop_ready = s1_ready;
   assign s1_load   = pop_valid && s1_ready;
   assign s2_load   = s1_valid_ff && s2_ready;

   always_comb begin
      s1_valid_in = s1_ready ? pop_valid : s1_valid_ff;
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   end

   // Scaled values; fields stay zero for a busy or CRC error item.
   always_comb begin
      s2_hum_centi_in  = '0;
      s2_temp_centi_in = '0;
      if (s1_frame_ff.status == STATUS_OK) begin
         s2_hum_centi_in  = s1_hum_prod_ff[HUM_PROD_W-1 -: HUM_W];
         s2_temp_centi_in = s1_temp_prod_ff[TEMP_PROD_W-1 -: TEMP_W] - TEMP_OFFSET;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Stage one: constant multiplications.
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_frame_ff     <= pop_data;
         s1_hum_prod_ff  <= HUM_PROD_W'(pop_data.humidity_raw) * HUM_PROD_W'(HUM_SCALE);
         s1_temp_prod_ff <= TEMP_PROD_W'(pop_data.temperature_raw)
                            * TEMP_PROD_W'(TEMP_SCALE);
      end
   end

   // Stage two: result register.
   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_status_ff     <= s1_frame_ff.status;
         s2_hum_raw_ff    <= s1_frame_ff.humidity_raw;
         s2_temp_raw_ff   <= s1_frame_ff.temperature_raw;
         s2_hum_centi_ff  <= s2_hum_centi_in;
         s2_temp_centi_ff <= s2_temp_centi_in;
      end
   end

   assign rsp_valid             = s2_valid_ff;
   assign rsp_status            = s2_status_ff;
   assign rsp_humidity_raw      = s2_hum_raw_ff;
   assign rsp_temperature_raw   = s2_temp_raw_ff;
   assign rsp_humidity_centi    = s2_hum_centi_ff;
   assign rsp_temperature_centi = s2_temp_centi_ff;

endmodule

>>> hdl/humidity_temperature_frame_decoder.sv
// ----------------------------------------------------------------------------
// Humidity and temperature frame decoder
// Decodes the seven-byte measurement response of a humidity and temperature
// sensor into raw and scaled readings, with busy and CRC checks.
//
//   Channel  Direction  Payload
//   req_     in         rx_byte, frame_start (one response byte per item)
//   rsp_     out        status, humidity/temperature raw and centi values
//
// One byte item is taken per cycle while the frame queue has room. The seventh
// byte of a frame is written into the queue at the edge that takes it, then
// moves through the multiply stage and the output stage, whose register
// drives rsp_valid and holds the result item until it is taken.
// The front end stalls only when the four-entry frame queue is full.
// A stalled result holds in the output register while bytes keep flowing.
// Synchronous reset clears the byte index, the CRC and all valid state.
// ----------------------------------------------------------------------------
module humidity_temperature_frame_decoder
   import htfd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_rx_byte,
   input  logic                      req_frame_start,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output logic [RAW_W-1:0]          rsp_humidity_raw,
   output logic [RAW_W-1:0]          rsp_temperature_raw,
   output logic [HUM_W-1:0]          rsp_humidity_centi,
   output logic signed [TEMP_W-1:0]  rsp_temperature_centi
);

   logic       push_valid;
   logic       push_ready;
   frame_type  push_data;
   logic       pop_valid;
   logic       pop_ready;
   frame_type  pop_data;

   // Byte intake and frame classification.
   htfd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .req_frame_start (req_frame_start),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data)
   );

   // Frame queue.
   htfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Scaling and result output.
   htfd_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .pop_valid             (pop_valid),
      .pop_ready             (pop_ready),
      .pop_data              (pop_data),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_humidity_raw      (rsp_humidity_raw),
      .rsp_temperature_raw   (rsp_temperature_raw),
      .rsp_humidity_centi    (rsp_humidity_centi),
      .rsp_temperature_centi (rsp_temperature_centi)
   );

endmodule

>>> sim/humidity_temperature_frame_decoder_tb.sv
// ----------------------------------------------------------------------------
// Humidity and temperature frame decoder testbench
// Sends sensor response bytes into the decoder and checks every reading that
// comes back against a cycle-free model of the frame decoding kept here. The
// run covers known frames at the extremes, random well-formed frames with busy
// and CRC faults, truncated frames, stray bytes and start markers, and a
// pause until all readings have drained. Both channels idle at random.
// ----------------------------------------------------------------------------
module humidity_temperature_frame_decoder_tb;
   import htfd_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES   = 8;

   // Expected contents of one result item.
   typedef struct {
      status_type               status;
      logic [RAW_W-1:0]         hum_raw;
      logic [RAW_W-1:0]         temp_word;
      logic [HUM_W-1:0]         hum_centi;
      logic signed [TEMP_W-1:0] temp_centi;
   } reading_type;

   // Receiver behavior: always ready, a solid stall, or a random flicker.
   typedef enum logic [1:0] {
      RX_STEADY,
      RX_STALL,
      RX_JITTER
   } rx_mode_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [7:0]                req_rx_byte = 8'h00;
   logic                      req_frame_start = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [1:0]                rsp_status;
   logic [RAW_W-1:0]          rsp_humidity_raw;
   logic [RAW_W-1:0]          rsp_temperature_raw;
   logic [HUM_W-1:0]          rsp_humidity_centi;
   logic signed [TEMP_W-1:0]  rsp_temperature_centi;

   // Decoder state as seen by the prediction.
   logic [INDEX_W-1:0]  frame_pos = '0;
   logic [7:0]          crc_acc = CRC_INIT;
   logic [7:0]          frame_buf [DATA_BYTES];

   reading_type   pending_readings [$];
   int unsigned   items_sent = 0;
   int unsigned   readings_checked = 0;
   int unsigned   readings_ok = 0;
   int unsigned   readings_busy = 0;
   int unsigned   readings_crc_err = 0;
   int unsigned   mismatches = 0;
   int unsigned   burst_left = 0;
   int unsigned   idle_cycles = 0;
   rx_mode_type   rx_mode = RX_STEADY;
   int unsigned   rx_hold = 0;

   humidity_temperature_frame_decoder u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_rx_byte           (req_rx_byte),
      .req_frame_start       (req_frame_start),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_humidity_raw      (rsp_humidity_raw),
      .rsp_temperature_raw   (rsp_temperature_raw),
      .rsp_humidity_centi    (rsp_humidity_centi),
      .rsp_temperature_centi (rsp_temperature_centi)
   );

   // Clock with a period of two time units.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // CRC-8 update, one data bit at a time, MSB first.
   function automatic logic [7:0] crc8_accumulate(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] acc;
      logic       feedback;
      acc = crc;
      for (int i = 7; i >= 0; i--) begin
         feedback = acc[7] ^ data[i];
         acc = acc << 1;
         if (feedback) begin
            acc = acc ^ CRC_POLY;
         end
      end
      return acc;
   endfunction

   // Appends the correct CRC byte to six data bytes; byte 0 goes out first.
   function automatic logic [6:0][7:0] sealed_frame(input logic [5:0][7:0] body);
      logic [7:0] crc;
      crc = CRC_INIT;
      for (int i = 0; i < 6; i++) begin
         crc = crc8_accumulate(crc, body[i]);
      end
      return {crc, body};
   endfunction

   // Random data bytes; the status byte reports busy about one time in ten.
   function automatic logic [5:0][7:0] random_body();
      logic [5:0][7:0] body;
      for (int i = 0; i < 6; i++) begin
         body[i] = 8'($urandom);
      end
      body[0][7] = ($urandom_range(0, 9) == 0);
      return body;
   endfunction

   // Advances the decoder model by one accepted byte and queues any reading.
   task automatic decode_byte(input logic [7:0] rx, input logic start);
      reading_type r;
      logic [63:0] hum_prod;
      logic [63:0] temp_prod;
      if (start) begin
         frame_pos = '0;
         crc_acc   = CRC_INIT;
      end
      if (frame_pos < DATA_BYTES) begin
         frame_buf[frame_pos] = rx;
         crc_acc   = crc8_accumulate(crc_acc, rx);
         frame_pos = frame_pos + 1'b1;
      end else begin
         r.status     = STATUS_OK;
         r.hum_raw    = '0;
         r.temp_word  = '0;
         r.hum_centi  = '0;
         r.temp_centi = '0;
         if (frame_buf[0][7]) begin
            r.status = STATUS_BUSY;
         end else if (crc_acc != rx) begin
            r.status = STATUS_CRC_ERR;
         end else begin
            r.hum_raw    = {frame_buf[1], frame_buf[2], frame_buf[3][7:4]};
            r.temp_word  = {frame_buf[3][3:0], frame_buf[4], frame_buf[5]};
            hum_prod     = 64'(r.hum_raw) * 64'd10000;
            temp_prod    = 64'(r.temp_word) * 64'd20000;
            r.hum_centi  = HUM_W'(hum_prod >> 20);
            r.temp_centi = TEMP_W'(temp_prod >> 20) - TEMP_W'(5000);
         end
         pending_readings.push_back(r);
         frame_pos = '0;
         crc_acc   = CRC_INIT;
      end
   endtask

   // Offers one byte, waits for it to be taken, then maybe leaves a gap.
   task automatic send_byte(input logic [7:0] rx, input logic start);
      int unsigned gap;
      req_valid       <= 1'b1;
      req_rx_byte     <= rx;
      req_frame_start <= start;
      do begin
         @(posedge clock);
      end while (!req_ready);
      decode_byte(rx, start);
      items_sent++;
      if (burst_left == 0) begin
         gap        = $urandom_range(1, 8);
         burst_left = $urandom_range(1, 48);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   // Sends the first byte_count bytes of a frame.
   task automatic send_frame(input logic [6:0][7:0] frm, input logic start_first,
                             input int unsigned byte_count);
      for (int i = 0; i < byte_count; i++) begin
         send_byte(frm[i], start_first && (i == 0));
      end
   endtask

   // Random bytes with start markers sprinkled in at random places.
   task automatic send_noise(input int unsigned byte_count);
      for (int i = 0; i < byte_count; i++) begin
         send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end
   endtask

   // Holds the sender off until every queued reading has been returned.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Extremes of every field, busy and CRC faults, and a resync mid-frame.
   task automatic test_known_frames();
      logic [5:0][7:0] body;
      logic [6:0][7:0] frm;
      // All-zero readings, sent without a start marker right after reset.
      body = '0;
      send_frame(sealed_frame(body), 1'b0, 7);
      // Full-scale humidity and temperature.
      body = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h1C};
      send_frame(sealed_frame(body), 1'b1, 7);
      // Busy status wins even though the CRC byte is wrong.
      body = {8'h5A, 8'h3C, 8'hC3, 8'hA5, 8'h0F, 8'h98};
      frm = sealed_frame(body);
      frm[6] = ~frm[6];
      send_frame(frm, 1'b1, 7);
      // A frame cut short after two bytes, then a start marker and a bad CRC.
      send_frame(sealed_frame(random_body()), 1'b1, 2);
      body = {8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'h18};
      frm = sealed_frame(body);
      frm[6] = frm[6] ^ 8'h01;
      send_frame(frm, 1'b1, 7);
   endtask

   // Mostly well-formed frames, with bad CRCs, truncations and stray bytes.
   task automatic test_random_frames(input int unsigned item_count);
      int unsigned     stop_at;
      int unsigned     roll;
      logic [6:0][7:0] frm;
      stop_at = items_sent + item_count;
      while (items_sent < stop_at) begin
         roll = $urandom_range(0, 99);
         frm  = sealed_frame(random_body());
         if (roll < 70) begin
            send_frame(frm, $urandom_range(0, 4) != 0, 7);
         end else if (roll < 80) begin
            frm[6] = frm[6] ^ 8'($urandom_range(1, 255));
            send_frame(frm, 1'b1, 7);
         end else if (roll < 90) begin
            send_frame(frm, 1'b1, $urandom_range(1, 6));
         end else begin
            send_noise($urandom_range(1, 10));
         end
      end
   endtask

   // Frames on both sides of a pause in which the decoder empties out.
   task automatic test_drain_pause();
      for (int i = 0; i < 3; i++) begin
         send_frame(sealed_frame(random_body()), 1'b1, 7);
      end
      wait_drained();
      for (int i = 0; i < 3; i++) begin
         send_frame(sealed_frame(random_body()), 1'b1, 7);
      end
   endtask

   // A long run of noise, then a clean frame to show the decoder realigns.
   task automatic test_noise_resync();
      send_noise(120);
      send_frame(sealed_frame(random_body()), 1'b1, 7);
   endtask

   task automatic note_mismatch(input string field, input int want_v, input int got_v);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
      mismatches++;
   endtask

   // Receiver: switches between steady, stalled and flickering ready.
   always @(posedge clock) begin
      if (rx_hold == 0) begin
         case ($urandom_range(0, 2))
            0: begin
               rx_mode = RX_STEADY;
               rx_hold = $urandom_range(10, 60);
            end
            1: begin
               rx_mode = RX_STALL;
               rx_hold = $urandom_range(1, 12);
            end
            default: begin
               rx_mode = RX_JITTER;
               rx_hold = $urandom_range(4, 30);
            end
         endcase
      end
      rx_hold--;
      case (rx_mode)
         RX_STEADY: rsp_ready <= 1'b1;
         RX_STALL:  rsp_ready <= 1'b0;
         default:   rsp_ready <= 1'($urandom_range(0, 1));
      endcase
   end

   // Compares each returned reading with the oldest one predicted.
   always @(posedge clock) begin : check_readings
      reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: reading returned with none expected, status %0d", $time, rsp_status);
            mismatches++;
         end else begin
            want = pending_readings.pop_front();
            readings_checked++;
            case (want.status)
               STATUS_OK:   readings_ok++;
               STATUS_BUSY: readings_busy++;
               default:     readings_crc_err++;
            endcase
            if (rsp_status != want.status) begin
               note_mismatch("status", want.status, rsp_status);
            end
            if (rsp_humidity_raw != want.hum_raw) begin
               note_mismatch("humidity_raw", want.hum_raw, rsp_humidity_raw);
            end
            if (rsp_temperature_raw != want.temp_word) begin
               note_mismatch("temperature_raw", want.temp_word, rsp_temperature_raw);
            end
            if (rsp_humidity_centi != want.hum_centi) begin
               note_mismatch("humidity_centi", want.hum_centi, rsp_humidity_centi);
            end
            if (rsp_temperature_centi != want.temp_centi) begin
               note_mismatch("temperature_centi", int'(want.temp_centi),
                             int'(rsp_temperature_centi));
            end
         end
      end
   end

   // Watchdog: ends the run after too long without any item moving.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
            $display("FAIL");
            $finish;
         end
      end
   end

   // Test sequence.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_known_frames();
      test_random_frames(560);
      test_drain_pause();
      test_noise_resync();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d bytes and checked %0d readings: %0d valid, %0d busy, %0d CRC errors.",
               items_sent, readings_checked, readings_ok, readings_busy, readings_crc_err);
      $display("Covered full-scale and zero readings, truncated frames and stray start markers.");
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/htfd_pkg.sv
hdl/htfd_front.sv
hdl/htfd_queue.sv
hdl/htfd_back.sv
hdl/humidity_temperature_frame_decoder.sv
sim/humidity_temperature_frame_decoder_tb.sv
